>>> sv/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on every rising clock edge, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> sv/ema_pkg.sv
// ----------------------------------------------------------------------------
// ema_pkg
// Shared types and constants of the event metrics aggregator.
// ----------------------------------------------------------------------------
package ema_pkg;

  // Request codes
  localparam logic [3:0] REQ_TICK     = 4'd0;
  localparam logic [3:0] REQ_WEIGHT   = 4'd1;
  localparam logic [3:0] REQ_PRUNE    = 4'd2;
  localparam logic [3:0] REQ_SPROUT   = 4'd3;
  localparam logic [3:0] REQ_RATES    = 4'd4;
  localparam logic [3:0] REQ_SYNAPSES = 4'd5;
  localparam logic [3:0] REQ_PHASE    = 4'd6;
  localparam logic [3:0] REQ_ACCURACY = 4'd7;
  localparam logic [3:0] REQ_MEMORY   = 4'd8;
  localparam logic [3:0] REQ_VTIME    = 4'd9;
  localparam logic [3:0] REQ_READ     = 4'd10;

  // Configuration register indexes
  localparam logic [2:0] CFG_PAIR_A  = 3'd0;
  localparam logic [2:0] CFG_PAIR_B  = 3'd1;
  localparam logic [2:0] CFG_PAIR_C  = 3'd2;
  localparam logic [2:0] CFG_PAIR_D  = 3'd3;
  localparam logic [2:0] CFG_NEURONS = 3'd4;

  localparam logic [63:0] PAIR_A_RST = 64'd4294967296500000;
  localparam logic [63:0] PAIR_B_RST = 64'd21474836482000000;
  localparam logic [63:0] PAIR_C_RST = 64'd85899345930000000;
  localparam logic [63:0] PAIR_D_RST = 64'd429496729650000000;

  localparam logic [63:0] RATE_NUM = 64'd1000000000;

  localparam int BUCKET_SLOTS = 9;

  // Classified command handed from front to back
  typedef struct packed {
    logic [3:0]  req;
    logic [63:0] tick;
    logic [31:0] active;
    logic [31:0] spikes;
    logic [31:0] dur;
    logic [3:0]  slot;
    logic [63:0] v1;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [4:0]  sel;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FRAC, ST_RATE, ST_BAL, ST_DIV, ST_OUT
  } bst_t;

  // Saturate 64-bit signed to 32-bit signed
  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic hi_ok;
    hi_ok = (v[63:31] == '0) || (v[63:31] == '1);
    if (hi_ok) return v[31:0];
    else if (v[63]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

endpackage

>>> sv/ema_front.sv
// ----------------------------------------------------------------------------
// ema_front
// Accepts request beats, saturates Q16.16 operands, picks the histogram
// bucket and pushes a classified command into a two-entry queue.
// ----------------------------------------------------------------------------
module ema_front #(
  parameter int NUM_BOUNDS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [3:0]         in_req_type,
  input  logic [63:0]        in_tick_number,
  input  logic [31:0]        in_active_count,
  input  logic [31:0]        in_spike_count,
  input  logic [31:0]        in_duration_ns,
  input  logic [63:0]        in_value_first,
  input  logic [63:0]        in_value_second,
  input  logic [4:0]         in_metric_select,
  input  logic [4:0][63:0]   bounds,
  output logic               q_valid,
  output ema_pkg::cmd_t      q_cmd,
  input  logic               q_take
);

  ema_pkg::cmd_t cmd;
  ema_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push_ok;

  // Bucket pick: first bound not below the duration
  always_comb begin
    logic [3:0] s;
    logic [31:0] b;
    s = 4'(NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      b = i[0] ? bounds[i >> 1][63:32] : bounds[i >> 1][31:0];
      if (in_duration_ns <= b) s = 4'(i);
    end
    cmd.req    = in_req_type;
    cmd.tick   = in_tick_number;
    cmd.active = in_active_count;
    cmd.spikes = in_spike_count;
    cmd.dur    = in_duration_ns;
    cmd.slot   = s;
    cmd.v1     = in_value_first;
    cmd.q1     = ema_pkg::sat32(in_value_first);
    cmd.q2     = ema_pkg::sat32(in_value_second);
    cmd.sel    = in_metric_select;
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (q_take)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(q_take);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= cmd;
  end

endmodule

>>> sv/ema_div.sv
// ----------------------------------------------------------------------------
// ema_div
// Shared radix-2 unsigned divider, 64-bit dividend, 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ema_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], q_r[63]};
  assign quot  = q_r;
  assign done  = busy_r && (cnt_r == 7'd0);

  // Iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r && cnt_r != 7'd0) begin
      if (trial >= {1'b0, d_r}) begin
        rem_r <= trial - {1'b0, d_r};
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/ema_back.sv
// ----------------------------------------------------------------------------
// ema_back
// Executes queued commands: updates metric state, runs divisions on the
// shared divider and posts read results into a one-entry output register.
// ----------------------------------------------------------------------------
module ema_back #(
  parameter int NUM_BOUNDS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ema_pkg::cmd_t  q_cmd,
  output logic           q_take,
  input  logic [31:0]    neuron_total,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [63:0]    out_metric_value
);

  localparam logic [63:0] RATE_NUM_SH = ema_pkg::RATE_NUM << 32;

  ema_pkg::bst_t st_r, st_nxt;
  ema_pkg::cmd_t c_r;

  logic [63:0] last_tick_r;
  logic [31:0] last_active_r, last_spikes_r, last_duration_r;
  logic [15:0] frac_r;
  logic [63:0] dsum_r, devt_r, rate_r;
  logic [31:0] bucket_r [ema_pkg::BUCKET_SLOTS];
  logic [31:0] pair_r [9];
  logic [63:0] tot_r [5];
  logic        ov_r;
  logic [63:0] ov_data_r;

  logic        div_start, div_done;
  logic [63:0] div_a, div_q;
  logic [31:0] div_b;
  logic        bal_neg;
  logic [63:0] rd;

  ema_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quot(div_q)
  );

  assign out_empty        = !ov_r;
  assign out_metric_value = ov_data_r;

  // Magnitudes for the signed balance division
  logic [31:0] e_mag, i_mag;
  assign e_mag   = c_r.q1[31] ? (32'd0 - c_r.q1) : c_r.q1;
  assign i_mag   = c_r.q2[31] ? (32'd0 - c_r.q2) : c_r.q2;
  assign bal_neg = c_r.q1[31] ^ c_r.q2[31];

  // Metric read mux
  always_comb begin
    rd = '0;
    if (c_r.sel <= 5'd7) begin
      case (c_r.sel[2:0])
        3'd0: rd = last_tick_r;
        3'd1: rd = {32'd0, last_active_r};
        3'd2: rd = {32'd0, last_spikes_r};
        3'd3: rd = {32'd0, last_duration_r};
        3'd4: rd = {48'd0, frac_r};
        3'd5: rd = dsum_r;
        3'd6: rd = devt_r;
        default: rd = rate_r;
      endcase
    end else if (c_r.sel <= 5'd16) begin
      if ((c_r.sel - 5'd8) <= 5'(NUM_BOUNDS))
        rd = {32'd0, bucket_r[4'(c_r.sel - 5'd8)]};
    end else if (c_r.sel <= 5'd25) begin
      rd = {32'd0, pair_r[4'(c_r.sel - 5'd17)]};
    end else if (c_r.sel <= 5'd30) begin
      rd = tot_r[3'(c_r.sel - 5'd26)];
    end
  end

  // Sequencer: next state and divider hookup
  always_comb begin
    st_nxt    = st_r;
    q_take    = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (st_r)
      ema_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          st_nxt = ema_pkg::ST_DIV;
        end
      end
      ema_pkg::ST_DIV: begin
        if (c_r.req == ema_pkg::REQ_TICK) begin
          st_nxt = ema_pkg::ST_FRAC;
          div_start = 1'b1;
          div_a = {17'd0, c_r.active, 15'd0};
          div_b = neuron_total;
        end else if (c_r.req == ema_pkg::REQ_RATES) begin
          st_nxt = ema_pkg::ST_BAL;
          div_start = 1'b1;
          div_a = {16'd0, e_mag, 16'd0};
          div_b = i_mag;
        end else if (c_r.req == ema_pkg::REQ_READ) begin
          st_nxt = ema_pkg::ST_OUT;
        end else begin
          st_nxt = ema_pkg::ST_IDLE;
        end
      end
      ema_pkg::ST_FRAC: begin
        if (div_done) begin
          st_nxt = ema_pkg::ST_RATE;
          div_start = 1'b1;
          div_a = RATE_NUM_SH;
          div_b = c_r.dur;
        end
      end
      ema_pkg::ST_RATE: if (div_done) st_nxt = ema_pkg::ST_IDLE;
      ema_pkg::ST_BAL:  if (div_done) st_nxt = ema_pkg::ST_IDLE;
      ema_pkg::ST_OUT:  if (!ov_r || out_pop) st_nxt = ema_pkg::ST_IDLE;
      default: st_nxt = ema_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ema_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_take) c_r <= q_cmd;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (st_r == ema_pkg::ST_OUT && (!ov_r || out_pop)) begin
      ov_r <= 1'b1;
    end else if (out_pop) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (st_r == ema_pkg::ST_OUT && (!ov_r || out_pop)) ov_data_r <= rd;
  end

  // Metric state updates
  always_ff @(posedge clk) begin
    logic [64:0] s;
    logic [63:0] bq;
    if (!rst_n) begin
      last_tick_r <= '0; last_active_r <= '0; last_spikes_r <= '0;
      last_duration_r <= '0; frac_r <= '0; dsum_r <= '0; devt_r <= '0;
      rate_r <= '0;
      for (int i = 0; i < ema_pkg::BUCKET_SLOTS; i++) bucket_r[i] <= '0;
      for (int i = 0; i < 9; i++) pair_r[i] <= '0;
      for (int i = 0; i < 5; i++) tot_r[i] <= '0;
    end else if (st_r == ema_pkg::ST_DIV) begin
      case (c_r.req)
        ema_pkg::REQ_TICK: begin
          last_tick_r <= c_r.tick;
          last_active_r <= c_r.active;
          last_spikes_r <= c_r.spikes;
          last_duration_r <= c_r.dur;
          s = {1'b0, dsum_r} + {33'd0, c_r.dur};
          dsum_r <= s[64] ? '1 : s[63:0];
          if (devt_r != '1) devt_r <= devt_r + 64'd1;
          if (bucket_r[c_r.slot] != '1) bucket_r[c_r.slot] <= bucket_r[c_r.slot] + 32'd1;
        end
        ema_pkg::REQ_WEIGHT:   begin pair_r[0] <= c_r.q1; pair_r[1] <= c_r.q2; end
        ema_pkg::REQ_RATES:    begin pair_r[2] <= c_r.q1; pair_r[3] <= c_r.q2; end
        ema_pkg::REQ_PHASE:    begin pair_r[5] <= c_r.q1; pair_r[6] <= c_r.q2; end
        ema_pkg::REQ_ACCURACY: begin pair_r[7] <= c_r.q1; pair_r[8] <= c_r.q2; end
        ema_pkg::REQ_PRUNE: begin
          s = {1'b0, tot_r[0]} + {1'b0, c_r.v1};
          tot_r[0] <= s[64] ? '1 : s[63:0];
        end
        ema_pkg::REQ_SPROUT: begin
          s = {1'b0, tot_r[1]} + {1'b0, c_r.v1};
          tot_r[1] <= s[64] ? '1 : s[63:0];
        end
        ema_pkg::REQ_SYNAPSES: tot_r[2] <= c_r.v1;
        ema_pkg::REQ_MEMORY:   tot_r[3] <= c_r.v1;
        ema_pkg::REQ_VTIME:    tot_r[4] <= c_r.v1;
        default: ;
      endcase
    end else if (st_r == ema_pkg::ST_FRAC && div_done) begin
      if (neuron_total == '0) frac_r <= '0;
      else frac_r <= (div_q > 64'hFFFF) ? 16'hFFFF : div_q[15:0];
    end else if (st_r == ema_pkg::ST_RATE && div_done) begin
      if (c_r.dur != '0) rate_r <= div_q;
    end else if (st_r == ema_pkg::ST_BAL && div_done) begin
      bq = bal_neg ? (64'd0 - div_q) : div_q;
      pair_r[4] <= (c_r.q2 == '0) ? 32'd0 : ema_pkg::sat32(bq);
    end
  end

endmodule

>>> sv/event_metrics_aggregator_unit.sv
// Sequencing: a tick runs the fraction and then the rate division, a rates
//   request the balance division; a read waits for a free output register.
// Back end: one command at a time, divisions on the shared one-bit-per-cycle
//   divider; a two-entry queue decouples the input side.
// Reset: synchronous active-low; all metrics clear, bounds take defaults.
// ----------------------------------------------------------------------------
// event_metrics_aggregator_unit
// Telemetry event aggregator with histogram and metric readback.
// ----------------------------------------------------------------------------
module event_metrics_aggregator_unit #(
  parameter int NUM_BOUNDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_req_type,
  input  logic [63:0] in_tick_number,
  input  logic [31:0] in_active_count,
  input  logic [31:0] in_spike_count,
  input  logic [31:0] in_duration_ns,
  input  logic signed [63:0] in_value_first,
  input  logic signed [63:0] in_value_second,
  input  logic [4:0]  in_metric_select,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_metric_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0][63:0] bounds;
  logic [63:0] pa_r, pb_r, pc_r, pd_r;
  logic [31:0] nt_r;
  logic        q_valid, q_take;
  ema_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;
  assign bounds = {64'd0, pd_r, pc_r, pb_r, pa_r};

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= ema_pkg::PAIR_A_RST; pb_r <= ema_pkg::PAIR_B_RST;
      pc_r <= ema_pkg::PAIR_C_RST; pd_r <= ema_pkg::PAIR_D_RST;
      nt_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ema_pkg::CFG_PAIR_A:  pa_r <= cfg_data;
        ema_pkg::CFG_PAIR_B:  pb_r <= cfg_data;
        ema_pkg::CFG_PAIR_C:  pc_r <= cfg_data;
        ema_pkg::CFG_PAIR_D:  pd_r <= cfg_data;
        ema_pkg::CFG_NEURONS: nt_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ema_front #(.NUM_BOUNDS(NUM_BOUNDS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_req_type(in_req_type), .in_tick_number(in_tick_number),
    .in_active_count(in_active_count), .in_spike_count(in_spike_count),
    .in_duration_ns(in_duration_ns), .in_value_first(in_value_first),
    .in_value_second(in_value_second), .in_metric_select(in_metric_select),
    .bounds(bounds), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  ema_back #(.NUM_BOUNDS(NUM_BOUNDS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_take(q_take), .neuron_total(nt_r), .out_empty(out_empty),
    .out_pop(out_pop), .out_metric_value(out_metric_value)
  );

endmodule

>>> sv/ema_checker.sv
// ----------------------------------------------------------------------------
// ema_checker
// Port-level checks of the aggregator's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ema_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_metric_value
);

  `ASSERT_NEXT(a_hold_val, clk, rst_n, !out_empty && !out_pop, $stable(out_metric_value))
  `ASSERT_NEXT(a_hold_vld, clk, rst_n, !out_empty && !out_pop, !out_empty)
  `ASSERT_IMPL(a_known, clk, rst_n, !out_empty, !$isunknown(out_metric_value))

endmodule

bind event_metrics_aggregator_unit ema_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_empty(out_empty), .out_pop(out_pop), .out_metric_value(out_metric_value)
);

>>> sim/event_metrics_aggregator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_metrics_aggregator_unit_tb
// Self-checking bench: a directed table, then random telemetry traffic over
// several bound and neuron-total settings. Every read beat is compared with
// a table value or a metric-store model; bursty sender, stalling receiver.
// ----------------------------------------------------------------------------
module event_metrics_aggregator_unit_tb;

  localparam int  IDLE_WAIT   = 1000;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  RAND_PHASE  = 200;

  typedef struct {
    logic [3:0]         req;
    logic [63:0]        tick;
    logic [31:0]        active;
    logic [31:0]        spikes;
    logic [31:0]        dur;
    logic signed [63:0] v1;
    logic signed [63:0] v2;
    logic [4:0]         sel;
    bit                 fixed;
    logic [63:0]        want;
  } req_item_t;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [3:0] in_req_type = '0;
  logic [63:0] in_tick_number = '0;
  logic [31:0] in_active_count = '0;
  logic [31:0] in_spike_count = '0;
  logic [31:0] in_duration_ns = '0;
  logic signed [63:0] in_value_first = '0;
  logic signed [63:0] in_value_second = '0;
  logic [4:0] in_metric_select = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [63:0] out_metric_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  event_metrics_aggregator_unit dut (.*);

  // clock
  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  // model state of the metric store
  logic [63:0] m_pairs [4];
  logic [31:0] m_neurons;
  logic [63:0] m_tick;
  logic [31:0] m_active, m_spikes, m_dur;
  logic [15:0] m_frac;
  logic [63:0] m_dsum, m_devents, m_rate;
  logic [31:0] m_buckets [ema_pkg::BUCKET_SLOTS];
  logic [31:0] m_qvals [10];
  logic [63:0] m_totals [5];

  logic [63:0] read_queue [$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
    errors++;
  endtask

  function automatic logic [31:0] clamp_q(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] metric_at(logic [4:0] sel);
    if (sel <= 5'd7) begin
      case (sel)
        5'd0: return m_tick;
        5'd1: return {32'b0, m_active};
        5'd2: return {32'b0, m_spikes};
        5'd3: return {32'b0, m_dur};
        5'd4: return {48'b0, m_frac};
        5'd5: return m_dsum;
        5'd6: return m_devents;
        default: return m_rate;
      endcase
    end
    if (sel <= 5'd16) return {32'b0, m_buckets[sel - 8]};
    if (sel <= 5'd25) return {32'b0, m_qvals[sel - 17]};
    if (sel <= 5'd30) return m_totals[sel - 26];
    return '0;
  endfunction

  task automatic model_reset();
    m_pairs = '{ema_pkg::PAIR_A_RST, ema_pkg::PAIR_B_RST,
                ema_pkg::PAIR_C_RST, ema_pkg::PAIR_D_RST};
    m_neurons = '0;
    m_tick = '0; m_active = '0; m_spikes = '0; m_dur = '0; m_frac = '0;
    m_dsum = '0; m_devents = '0; m_rate = '0;
    foreach (m_buckets[i]) m_buckets[i] = '0;
    foreach (m_qvals[i]) m_qvals[i] = '0;
    foreach (m_totals[i]) m_totals[i] = '0;
  endtask

  // update the model for one accepted request; reads queue the expected value
  task automatic model_apply(req_item_t it);
    logic [47:0] q;
    logic [31:0] bnd;
    logic signed [63:0] num, den;
    int slot;
    case (it.req)
      ema_pkg::REQ_TICK: begin
        m_tick = it.tick; m_active = it.active; m_spikes = it.spikes; m_dur = it.dur;
        if (m_neurons == 0) m_frac = '0;
        else begin
          q = {it.active, 15'b0} / {16'b0, m_neurons};
          m_frac = (q > 48'hFFFF) ? 16'hFFFF : q[15:0];
        end
        m_dsum = add_sat(m_dsum, {32'b0, it.dur});
        m_devents = add_sat(m_devents, 64'd1);
        slot = 8;
        for (int i = 7; i >= 0; i--) begin
          bnd = i[0] ? m_pairs[i >> 1][63:32] : m_pairs[i >> 1][31:0];
          if (it.dur <= bnd) slot = i;
        end
        if (m_buckets[slot] != '1) m_buckets[slot]++;
        if (it.dur != 0) m_rate = (ema_pkg::RATE_NUM << 32) / {32'b0, it.dur};
      end
      ema_pkg::REQ_WEIGHT: begin
        m_qvals[0] = clamp_q(it.v1); m_qvals[1] = clamp_q(it.v2);
      end
      ema_pkg::REQ_PRUNE:  m_totals[0] = add_sat(m_totals[0], it.v1);
      ema_pkg::REQ_SPROUT: m_totals[1] = add_sat(m_totals[1], it.v1);
      ema_pkg::REQ_RATES: begin
        m_qvals[2] = clamp_q(it.v1);
        m_qvals[3] = clamp_q(it.v2);
        if (m_qvals[3] == 0) m_qvals[4] = '0;
        else begin
          num = $signed({{32{m_qvals[2][31]}}, m_qvals[2]}) <<< 16;
          den = $signed({{32{m_qvals[3][31]}}, m_qvals[3]});
          m_qvals[4] = clamp_q(num / den);
        end
      end
      ema_pkg::REQ_SYNAPSES: m_totals[2] = it.v1;
      ema_pkg::REQ_PHASE: begin
        m_qvals[5] = clamp_q(it.v1); m_qvals[6] = clamp_q(it.v2);
      end
      ema_pkg::REQ_ACCURACY: begin
        m_qvals[7] = clamp_q(it.v1); m_qvals[8] = clamp_q(it.v2);
      end
      ema_pkg::REQ_MEMORY: m_totals[3] = it.v1;
      ema_pkg::REQ_VTIME:  m_totals[4] = it.v1;
      ema_pkg::REQ_READ:   read_queue.push_back(it.fixed ? it.want : metric_at(it.sel));
      default: ;
    endcase
  endtask

  // drive a request from a falling edge, return on the falling edge once taken
  task automatic send_req(req_item_t it);
    in_push = 1'b1;
    in_req_type = it.req; in_tick_number = it.tick; in_active_count = it.active;
    in_spike_count = it.spikes; in_duration_ns = it.dur;
    in_value_first = it.v1; in_value_second = it.v2; in_metric_select = it.sel;
    do @(posedge clk); while (in_full);
    model_apply(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < ema_pkg::CFG_NEURONS) m_pairs[idx] = data;
    else if (idx == ema_pkg::CFG_NEURONS) m_neurons = data[31:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending and let the block drain, events included
  task automatic drain();
    in_push = 1'b0;
    while (read_queue.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  function automatic req_item_t row(logic [3:0] req, logic [63:0] tick, logic [31:0] dur,
                                    logic [63:0] v1, logic [63:0] v2, logic [4:0] sel,
                                    bit fixed, logic [63:0] want);
    req_item_t it;
    it.req = req; it.tick = tick; it.active = tick[31:0]; it.spikes = tick[63:32];
    it.dur = dur; it.v1 = v1; it.v2 = v2; it.sel = sel; it.fixed = fixed; it.want = want;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_q();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return $signed(64'($signed(32'($urandom))));
      2: return $signed(64'($signed(20'($urandom))));
      default: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
    endcase
  endfunction

  function automatic req_item_t rand_item();
    req_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.req = ema_pkg::REQ_TICK;
    else if (pick < 65) it.req = ema_pkg::REQ_READ;
    else if (pick < 97) it.req = 4'($urandom_range(1, 9));
    else it.req = 4'($urandom_range(11, 15));
    it.tick = rand64();
    it.active = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000);
    it.spikes = $urandom;
    case ($urandom_range(0, 4))
      0: it.dur = $urandom;
      1: it.dur = $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
      default: it.dur = $urandom_range(0, 120000000);
    endcase
    it.v1 = rand_q();
    it.v2 = $urandom_range(0, 9) == 0 ? 64'd0 : rand_q();
    it.sel = 5'($urandom);
    it.fixed = 1'b0; it.want = '0;
    return it;
  endfunction

  // receiver: stall pattern rotates through always, random and sparse pops
  always @(negedge clk) begin
    case ((cycles >> 9) % 3)
      0: out_pop = 1'b1;
      1: out_pop = ($urandom_range(0, 1) == 1);
      default: out_pop = (((cycles >> 3) & 7) == 0);
    endcase
  end

  // result check and run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_pop && !out_empty) begin
      if (read_queue.size() == 0) report_mismatch("unexpected beat", '0, out_metric_value);
      else if (read_queue[0] !== out_metric_value) begin
        report_mismatch("metric_value", read_queue[0], out_metric_value);
        void'(read_queue.pop_front());
      end else void'(read_queue.pop_front());
    end
  end

  initial begin
    req_item_t tbl [$];
    req_item_t it;
    int burst, gap;
    logic [63:0] ones;
    ones = '1;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset values, extremes, every request code
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd0, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd7, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd16, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd31, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_TICK, ones, 0, 0, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd7, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd0, 1, ones));
    tbl.push_back(row(ema_pkg::REQ_TICK, 64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF,
                      0, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd16, 1, 64'd1));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd7, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_PRUNE, 0, 0, 64'd5, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_PRUNE, 0, 0, ones, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd26, 1, ones));
    tbl.push_back(row(ema_pkg::REQ_SPROUT, 0, 0, 64'd5, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd27, 1, 64'd5));
    tbl.push_back(row(ema_pkg::REQ_RATES, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd21, 1, 64'd0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd19, 1, 64'h7FFF_FFFF));
    tbl.push_back(row(ema_pkg::REQ_RATES, 0, 0, 64'h8000_0000_0000_0000, 64'd1,
                      0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'd21, 1, 64'h8000_0000));
    tbl.push_back(row(ema_pkg::REQ_WEIGHT, 0, 0, -64'sd3, 64'd70000, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_PHASE, 0, 0, 64'd1, ones, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_ACCURACY, 0, 0, 64'd65536, 64'd32768, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_SYNAPSES, 0, 0, ones, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_MEMORY, 0, 0, 64'd4096, 0, 0, 0, 0));
    tbl.push_back(row(ema_pkg::REQ_VTIME, 0, 0, 64'd77, 0, 0, 0, 0));
    tbl.push_back(row(4'd11, 0, 0, 0, 0, 0, 0, 0));
    tbl.push_back(row(4'd15, 0, 0, 0, 0, 0, 0, 0));
    for (int s = 17; s <= 30; s++)
      tbl.push_back(row(ema_pkg::REQ_READ, 0, 0, 0, 0, 5'(s), 0, 0));
    foreach (tbl[i]) send_req(tbl[i]);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: ;
        1: begin
          write_reg(ema_pkg::CFG_NEURONS, 64'd1);
          write_reg(ema_pkg::CFG_PAIR_A, '0);
          write_reg(ema_pkg::CFG_PAIR_B, ones);
        end
        2: begin
          write_reg(ema_pkg::CFG_NEURONS, 64'hFFFF_FFFF);
          write_reg(ema_pkg::CFG_PAIR_C, {32'd1000, 32'd90000000});
          write_reg(ema_pkg::CFG_PAIR_D, ones);
          write_reg(3'd5, rand64());
          write_reg(3'd7, rand64());
        end
        3: begin
          write_reg(ema_pkg::CFG_NEURONS, $urandom_range(1, 3000));
          for (int r = 0; r < 4; r++)
            write_reg(3'(r), {32'($urandom_range(0, 120000000)),
                              32'($urandom_range(0, 120000000))});
        end
        4: begin
          write_reg(ema_pkg::CFG_NEURONS, '0);
          for (int r = 0; r < 4; r++) write_reg(3'(r), rand64());
        end
        default: begin
          write_reg(ema_pkg::CFG_NEURONS, 64'd1000);
          write_reg(ema_pkg::CFG_PAIR_A, ema_pkg::PAIR_A_RST);
          write_reg(ema_pkg::CFG_PAIR_B, ema_pkg::PAIR_B_RST);
          write_reg(ema_pkg::CFG_PAIR_C, ema_pkg::PAIR_C_RST);
          write_reg(ema_pkg::CFG_PAIR_D, ema_pkg::PAIR_D_RST);
        end
      endcase
      for (int n = 0; n < RAND_PHASE; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < RAND_PHASE; b++) begin
          it = rand_item();
          send_req(it);
          if (it.req <= ema_pkg::REQ_READ) n++;
        end
        gap = (ph % 2) ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
          in_push = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    // wind down
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
